[rtl/wcrw_pkg.sv]
// ----------------------------------------------------------------------------
// wcrw_pkg
// Shared types, codes and helpers for the wheel command refresh watchdog.
// ----------------------------------------------------------------------------
package wcrw_pkg;

  // Number of wheels driven by the block.
  localparam int unsigned WheelCount = 4;

  // Width of the elapsed-tick counters.
  localparam int unsigned CountWidth = 17;

  // Configuration register indexes and reset values.
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 16;
  localparam logic [CfgIndexWidth-1:0] RegSpeedLimit      = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegResendPeriod    = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegFeedbackTimeout = 2'd2;
  localparam logic [14:0] SpeedLimitReset      = 15'd300;
  localparam logic [15:0] ResendPeriodReset    = 16'd50;
  localparam logic [15:0] FeedbackTimeoutReset = 16'd1000;

  // Input action codes.
  typedef enum logic [2:0] {
    ACT_TICK        = 3'd0,
    ACT_SET_WHEELS  = 3'd1,
    ACT_SET_DRIVE   = 3'd2,
    ACT_STOP        = 3'd3,
    ACT_STOP_OUTPUT = 3'd4
  } action_e;

  // Result command kinds.
  typedef enum logic [1:0] {
    KIND_SPEEDS      = 2'd0,
    KIND_STOP        = 2'd1,
    KIND_STOP_OUTPUT = 2'd2
  } kind_e;

  // Input transaction payload.
  typedef struct packed {
    logic [2:0]         action;
    logic signed [15:0] wheel_one_in;
    logic signed [15:0] wheel_two_in;
    logic signed [15:0] wheel_three_in;
    logic signed [15:0] wheel_four_in;
    logic signed [15:0] forward_speed;
    logic signed [15:0] turn_rate;
    logic               feedback_recent;
  } cmd_t;

  // Result transaction payload.
  typedef struct packed {
    logic [1:0]         command_kind;
    logic signed [15:0] wheel_one_out;
    logic signed [15:0] wheel_two_out;
    logic signed [15:0] wheel_three_out;
    logic signed [15:0] wheel_four_out;
    logic               timed_out;
  } result_t;

  // Saturate a wide speed request to plus or minus the limit.
  function automatic logic signed [15:0] clamp_speed(input logic signed [17:0] v,
                                                     input logic [14:0] lim);
    logic signed [17:0] lim_s;
    logic signed [17:0] neg_s;
    logic signed [17:0] res;
    lim_s = signed'({3'b000, lim});
    neg_s = -lim_s;
    if (v > lim_s) begin
      res = lim_s;
    end else if (v < neg_s) begin
      res = neg_s;
    end else begin
      res = v;
    end
    return res[15:0];
  endfunction

endpackage

[rtl/wcrw_stream_if.sv]
// ----------------------------------------------------------------------------
// wcrw_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface wcrw_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/wcrw_cfg_if.sv]
// ----------------------------------------------------------------------------
// wcrw_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface wcrw_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [wcrw_pkg::CfgIndexWidth-1:0]  index;
  logic [wcrw_pkg::CfgDataWidth-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/wheel_command_refresh_watchdog.sv]
// ----------------------------------------------------------------------------
// wheel_command_refresh_watchdog
// A taken input transaction is staged in the input register and evaluated
// into the result register; the evaluation waits while an earlier result
// is still held there and the staged item has a result of its own.
// Throughput: one input transaction per cycle; the input stage stalls only
// while a result is pending and the result register is still held.
// Reset: wheel targets, flags and tick counters clear; the speed limit,
// resend period and feedback timeout return to 300, 50 and 1000.
// Turns tick, speed and stop commands into motor commands, with periodic
// resend while moving and a feedback watchdog.
// ----------------------------------------------------------------------------
module wheel_command_refresh_watchdog (
  input  logic       clk_i,
  input  logic       rst_ni,
  wcrw_stream_if.sink   cmd_i,
  wcrw_stream_if.source res_o,
  wcrw_cfg_if.sink      cfg_i
);

  localparam int unsigned Wc = wcrw_pkg::WheelCount;
  localparam int unsigned Cw = wcrw_pkg::CountWidth;

  // Configuration registers.
  logic [14:0] speed_limit_q;
  logic [15:0] resend_period_q;
  logic [15:0] feedback_timeout_q;

  // Block state.
  logic signed [15:0] targets_q [Wc];
  logic signed [15:0] targets_d [Wc];
  logic               moving_q, moving_d;
  logic               changed_q, changed_d;
  logic [Cw-1:0]      since_send_q, since_send_d;
  logic [Cw-1:0]      since_move_q, since_move_d;

  // Input and result registers.
  logic              in_valid_q;
  wcrw_pkg::cmd_t    in_q;
  logic              out_valid_q;
  wcrw_pkg::result_t out_q;

  // Step logic.
  logic               has_result;
  wcrw_pkg::result_t  res_d;
  logic               out_free;
  logic               advance;
  logic signed [17:0] req [Wc];
  logic               do_set;
  logic signed [17:0] vx, wz;
  logic [Cw-1:0]      send_inc, move_inc;
  logic               any_nonzero;

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_limit_q      <= wcrw_pkg::SpeedLimitReset;
      resend_period_q    <= wcrw_pkg::ResendPeriodReset;
      feedback_timeout_q <= wcrw_pkg::FeedbackTimeoutReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        wcrw_pkg::RegSpeedLimit:      speed_limit_q      <= cfg_i.data[14:0];
        wcrw_pkg::RegResendPeriod:    resend_period_q    <= cfg_i.data;
        wcrw_pkg::RegFeedbackTimeout: feedback_timeout_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Handshake: the staged item moves on when it needs no result slot or the
  // result register is free or draining this cycle.
  assign out_free    = !out_valid_q || res_o.ready;
  assign advance     = in_valid_q && (!has_result || out_free);
  assign cmd_i.ready = !in_valid_q || advance;

  // Speed requests for the two set commands.
  assign vx = 18'(in_q.forward_speed);
  assign wz = 18'(in_q.turn_rate);

  always_comb begin
    if (wcrw_pkg::action_e'(in_q.action) == wcrw_pkg::ACT_SET_DRIVE) begin
      req[0] = vx + wz;
      req[1] = wz - vx;
      req[2] = vx - wz;
      req[3] = -vx - wz;
    end else begin
      req[0] = 18'(in_q.wheel_one_in);
      req[1] = 18'(in_q.wheel_two_in);
      req[2] = 18'(in_q.wheel_three_in);
      req[3] = 18'(in_q.wheel_four_in);
    end
  end

  // Saturating tick counters.
  assign send_inc = (&since_send_q) ? since_send_q : since_send_q + 1'b1;
  assign move_inc = (&since_move_q) ? since_move_q : since_move_q + 1'b1;

  // Evaluate the staged item against the current state.
  always_comb begin
    targets_d    = targets_q;
    moving_d     = moving_q;
    changed_d    = changed_q;
    since_send_d = since_send_q;
    since_move_d = since_move_q;
    has_result   = 1'b0;
    do_set       = 1'b0;
    any_nonzero  = 1'b0;
    res_d        = '0;
    res_d.command_kind = wcrw_pkg::KIND_SPEEDS;

    unique case (wcrw_pkg::action_e'(in_q.action)) inside
      wcrw_pkg::ACT_TICK: begin
        since_send_d = send_inc;
        since_move_d = move_inc;
        if (moving_q && (move_inc > {1'b0, feedback_timeout_q}) &&
            !in_q.feedback_recent) begin
          // Watchdog stop: no feedback long after the move started.
          moving_d           = 1'b0;
          changed_d          = 1'b0;
          has_result         = 1'b1;
          res_d.command_kind = wcrw_pkg::KIND_STOP;
          res_d.timed_out    = 1'b1;
        end else if (changed_q ||
                     (moving_q && !(send_inc < {1'b0, resend_period_q}))) begin
          // Send on change, or once per resend period while moving.
          since_send_d          = '0;
          changed_d             = 1'b0;
          has_result            = 1'b1;
          res_d.wheel_one_out   = targets_q[0];
          res_d.wheel_two_out   = targets_q[1];
          res_d.wheel_three_out = targets_q[2];
          res_d.wheel_four_out  = targets_q[3];
        end
      end
      wcrw_pkg::ACT_SET_WHEELS, wcrw_pkg::ACT_SET_DRIVE: begin
        do_set = 1'b1;
      end
      wcrw_pkg::ACT_STOP, wcrw_pkg::ACT_STOP_OUTPUT: begin
        for (int i = 0; i < Wc; i++) begin
          targets_d[i] = '0;
        end
        moving_d   = 1'b0;
        changed_d  = 1'b0;
        has_result = 1'b1;
        res_d.command_kind =
            (wcrw_pkg::action_e'(in_q.action) == wcrw_pkg::ACT_STOP) ?
            wcrw_pkg::KIND_STOP : wcrw_pkg::KIND_STOP_OUTPUT;
      end
      default: ;
    endcase

    // Set commands: clamp the new targets and restart the move timer.
    if (do_set) begin
      for (int i = 0; i < Wc; i++) begin
        targets_d[i] = wcrw_pkg::clamp_speed(req[i], speed_limit_q);
        any_nonzero  = any_nonzero | (targets_d[i] != '0);
      end
      moving_d     = any_nonzero;
      changed_d    = 1'b1;
      since_move_d = '0;
    end
  end

  // Input register, state update and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      moving_q     <= 1'b0;
      changed_q    <= 1'b0;
      since_send_q <= '0;
      since_move_q <= '0;
      for (int i = 0; i < Wc; i++) begin
        targets_q[i] <= '0;
      end
    end else begin
      if (cmd_i.ready) begin
        in_valid_q <= cmd_i.valid;
      end
      if (advance) begin
        moving_q     <= moving_d;
        changed_q    <= changed_d;
        since_send_q <= since_send_d;
        since_move_q <= since_move_d;
        targets_q    <= targets_d;
      end
      if (advance && has_result) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      in_q <= cmd_i.payload;
    end
    if (advance && has_result) begin
      out_q <= res_d;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wheel command refresh watchdog. A driver feeds
// command transactions from a queue, a predictor tracks the wheel targets,
// the flags and the tick counters, and a monitor compares every motor
// command with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TickSat = (1 << wcrw_pkg::CountWidth) - 1;
  localparam logic [wcrw_pkg::CfgIndexWidth-1:0] RegUnused = 2'd3;
  localparam int PhaseCount = 12;
  localparam int PhaseItems = 125;
  localparam int PlannedPhases = 9;

  logic clk_i;
  logic rst_ni;

  wcrw_stream_if #(.payload_t(wcrw_pkg::cmd_t))    cmd_if ();
  wcrw_stream_if #(.payload_t(wcrw_pkg::result_t)) res_if ();
  wcrw_cfg_if                                      cfg_if ();

  wheel_command_refresh_watchdog u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Register settings per phase; the extremes come first.
  int limit_plan   [PlannedPhases] = '{0, 32767, 1, 300, 50, 1000, 32767, 7, 120};
  int period_plan  [PlannedPhases] = '{1, 0, 65535, 3, 5, 2, 1, 4, 6};
  int timeout_plan [PlannedPhases] = '{1, 0, 65535, 8, 20, 4, 12, 65535, 2};

  // Predictor copy of the registers and of the block state.
  int limit_cfg;
  int period_cfg;
  int timeout_cfg;
  int wheel_goal [wcrw_pkg::WheelCount];
  bit in_motion;
  bit goal_dirty;
  int ticks_since_send;
  int ticks_since_start;

  wcrw_pkg::cmd_t    drive_q [$];
  wcrw_pkg::result_t motor_cmd_q [$];
  int                mismatch_cnt;

  bit tx_idle_en;
  bit rx_idle_en;
  int tx_gap_left;
  int rx_stall_left;
  int rx_hold_left;

  // Clock generation.
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Saturate a requested speed to the configured symmetric limit.
  function automatic int clip_speed(input int v);
    if (v > limit_cfg) return limit_cfg;
    if (v < -limit_cfg) return -limit_cfg;
    return v;
  endfunction

  function automatic int bump_ticks(input int c);
    return (c >= TickSat) ? TickSat : c + 1;
  endfunction

  // A set command loads clamped targets and restarts the move timer.
  function automatic void load_goals(input int req [wcrw_pkg::WheelCount]);
    bit any_nonzero;
    int i;
    any_nonzero = 1'b0;
    for (i = 0; i < wcrw_pkg::WheelCount; i++) begin
      wheel_goal[i] = clip_speed(req[i]);
      if (wheel_goal[i] != 0) any_nonzero = 1'b1;
    end
    in_motion = any_nonzero;
    goal_dirty = 1'b1;
    ticks_since_start = 0;
  endfunction

  // Advance the predicted state by one command and queue the motor command
  // that it causes, if any.
  function automatic void predict_motor_cmd(input wcrw_pkg::cmd_t c);
    int req [wcrw_pkg::WheelCount];
    int i;
    wcrw_pkg::result_t r;
    r = '0;
    unique case (c.action) inside
      wcrw_pkg::ACT_TICK: begin
        ticks_since_send = bump_ticks(ticks_since_send);
        ticks_since_start = bump_ticks(ticks_since_start);
        if (in_motion && ticks_since_start > timeout_cfg && !c.feedback_recent) begin
          // Feedback watchdog: stop, keep the targets.
          in_motion = 1'b0;
          goal_dirty = 1'b0;
          r.command_kind = wcrw_pkg::KIND_STOP;
          r.timed_out = 1'b1;
          motor_cmd_q.push_back(r);
        end else if (goal_dirty || (in_motion && ticks_since_send >= period_cfg)) begin
          ticks_since_send = 0;
          goal_dirty = 1'b0;
          r.command_kind = wcrw_pkg::KIND_SPEEDS;
          r.wheel_one_out = 16'(wheel_goal[0]);
          r.wheel_two_out = 16'(wheel_goal[1]);
          r.wheel_three_out = 16'(wheel_goal[2]);
          r.wheel_four_out = 16'(wheel_goal[3]);
          motor_cmd_q.push_back(r);
        end
      end
      wcrw_pkg::ACT_SET_WHEELS: begin
        req[0] = int'(c.wheel_one_in);
        req[1] = int'(c.wheel_two_in);
        req[2] = int'(c.wheel_three_in);
        req[3] = int'(c.wheel_four_in);
        load_goals(req);
      end
      wcrw_pkg::ACT_SET_DRIVE: begin
        req[0] = int'(c.forward_speed) + int'(c.turn_rate);
        req[1] = -int'(c.forward_speed) + int'(c.turn_rate);
        req[2] = int'(c.forward_speed) - int'(c.turn_rate);
        req[3] = -int'(c.forward_speed) - int'(c.turn_rate);
        load_goals(req);
      end
      wcrw_pkg::ACT_STOP, wcrw_pkg::ACT_STOP_OUTPUT: begin
        for (i = 0; i < wcrw_pkg::WheelCount; i++) wheel_goal[i] = 0;
        in_motion = 1'b0;
        goal_dirty = 1'b0;
        r.command_kind = (c.action == wcrw_pkg::ACT_STOP) ? wcrw_pkg::KIND_STOP
                                                          : wcrw_pkg::KIND_STOP_OUTPUT;
        motor_cmd_q.push_back(r);
      end
      default: begin
        // Unused action codes are ignored.
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Random speed: raw, zero, full scale, or close to the current limit.
  function automatic logic [15:0] pick_speed();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return 16'(0);
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'(int'($urandom_range(0, 2 * limit_cfg + 4)) - limit_cfg - 2);
    endcase
  endfunction

  function automatic wcrw_pkg::cmd_t rand_cmd(input logic [2:0] act);
    wcrw_pkg::cmd_t c;
    c.action = act;
    c.wheel_one_in = pick_speed();
    c.wheel_two_in = pick_speed();
    c.wheel_three_in = pick_speed();
    c.wheel_four_in = pick_speed();
    c.forward_speed = pick_speed();
    c.turn_rate = pick_speed();
    c.feedback_recent = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // Random stop request of either kind.
  function automatic wcrw_pkg::cmd_t rand_stop();
    return rand_cmd($urandom_range(0, 1) ? wcrw_pkg::ACT_STOP : wcrw_pkg::ACT_STOP_OUTPUT);
  endfunction

  function automatic wcrw_pkg::cmd_t build_cmd(input logic [2:0] act, input int w1,
                                               input int w2, input int w3, input int w4,
                                               input int vx, input int wz, input bit fb);
    wcrw_pkg::cmd_t c;
    c.action = act;
    c.wheel_one_in = 16'(w1);
    c.wheel_two_in = 16'(w2);
    c.wheel_three_in = 16'(w3);
    c.wheel_four_in = 16'(w4);
    c.forward_speed = 16'(vx);
    c.turn_rate = 16'(wz);
    c.feedback_recent = fb;
    return c;
  endfunction

  // Wait until every queued command is taken and every motor command has
  // arrived, then let commands without a result leave the pipeline.
  task automatic drain();
    while (drive_q.size() != 0 || motor_cmd_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // One register write transaction; the predictor follows on acceptance.
  task automatic write_reg(input logic [wcrw_pkg::CfgIndexWidth-1:0] idx, input int value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= 16'(value);
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    unique case (idx)
      wcrw_pkg::RegSpeedLimit:      limit_cfg = value & 16'h7fff;
      wcrw_pkg::RegResendPeriod:    period_cfg = value & 16'hffff;
      wcrw_pkg::RegFeedbackTimeout: timeout_cfg = value & 16'hffff;
      default: begin
        // Writes beyond the register file are dropped.
      end
    endcase
    @(negedge clk_i);
  endtask

  // Queue one random burst: mostly a set command followed by ticks, with
  // noise, bare stops and idle tick runs mixed in.
  task automatic queue_random_burst(inout int added);
    int n;
    int k;
    wcrw_pkg::cmd_t c;
    case ($urandom_range(0, 9))
      0: begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
          drive_q.push_back(rand_cmd(3'($urandom_range(0, 7))));
          added++;
        end
      end
      1: begin
        drive_q.push_back(rand_stop());
        added++;
      end
      2: begin
        n = $urandom_range(1, 10);
        for (k = 0; k < n; k++) begin
          drive_q.push_back(rand_cmd(wcrw_pkg::ACT_TICK));
          added++;
        end
      end
      default: begin
        drive_q.push_back(rand_cmd($urandom_range(0, 1) ? wcrw_pkg::ACT_SET_WHEELS
                                                        : wcrw_pkg::ACT_SET_DRIVE));
        added++;
        n = $urandom_range(1, 30);
        for (k = 0; k < n; k++) begin
          c = rand_cmd(wcrw_pkg::ACT_TICK);
          c.feedback_recent = ($urandom_range(0, 4) != 0);
          drive_q.push_back(c);
          added++;
        end
        if ($urandom_range(0, 2) == 0) begin
          drive_q.push_back(rand_stop());
          added++;
        end
      end
    endcase
  endtask

  // Command driver: presents the queue head and holds it until accepted.
  always @(posedge clk_i) begin
    bit offer;
    if (rst_ni) begin
      if (cmd_if.valid && cmd_if.ready) begin
        predict_motor_cmd(cmd_if.payload);
        void'(drive_q.pop_front());
      end
      if (!(cmd_if.valid && !cmd_if.ready)) begin
        if (tx_gap_left != 0) begin
          tx_gap_left--;
          offer = 1'b0;
        end else if (tx_idle_en && drive_q.size() != 0 && $urandom_range(0, 5) == 0) begin
          tx_gap_left = $urandom_range(0, 8);
          offer = 1'b0;
        end else begin
          offer = (drive_q.size() != 0);
        end
        cmd_if.valid <= offer;
        if (offer) cmd_if.payload <= drive_q[0];
      end
    end
  end

  // Long receiver hold-off, counted down on its own.
  always @(posedge clk_i) begin
    if (rx_hold_left != 0) rx_hold_left <= rx_hold_left - 1;
  end

  // Result monitor: checks each motor command transaction and paces ready.
  always @(posedge clk_i) begin
    wcrw_pkg::result_t want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (motor_cmd_q.size() == 0) begin
          $error("unexpected motor command, kind %0d", res_if.payload.command_kind);
          mismatch_cnt++;
        end else begin
          want = motor_cmd_q.pop_front();
          check_field("command_kind", want.command_kind, res_if.payload.command_kind);
          check_field("wheel_one_out", want.wheel_one_out, res_if.payload.wheel_one_out);
          check_field("wheel_two_out", want.wheel_two_out, res_if.payload.wheel_two_out);
          check_field("wheel_three_out", want.wheel_three_out,
                      res_if.payload.wheel_three_out);
          check_field("wheel_four_out", want.wheel_four_out, res_if.payload.wheel_four_out);
          check_field("timed_out", want.timed_out, res_if.payload.timed_out);
        end
      end
      if (rx_stall_left != 0) begin
        rx_stall_left--;
      end else if (rx_idle_en && $urandom_range(0, 6) == 0) begin
        rx_stall_left = $urandom_range(1, 9);
      end
      res_if.ready <= (rx_stall_left == 0) && (rx_hold_left == 0);
    end
  end

  // Stimulus sequence.
  initial begin
    int p;
    int added;
    int n;
    rst_ni = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.payload = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    limit_cfg = int'(wcrw_pkg::SpeedLimitReset);
    period_cfg = int'(wcrw_pkg::ResendPeriodReset);
    timeout_cfg = int'(wcrw_pkg::FeedbackTimeoutReset);
    foreach (wheel_goal[i]) wheel_goal[i] = 0;
    in_motion = 1'b0;
    goal_dirty = 1'b0;
    ticks_since_send = 0;
    ticks_since_start = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed commands under the reset settings.
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    drive_q.push_back(build_cmd(wcrw_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 1'b0));
    drive_q.push_back(build_cmd(wcrw_pkg::ACT_SET_WHEELS, 32767, -32768, 0, 5, 0, 0, 1'b0));
    drive_q.push_back(build_cmd(wcrw_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 1'b1));
    drive_q.push_back(build_cmd(wcrw_pkg::ACT_SET_DRIVE, 0, 0, 0, 0, -32768, -32768, 1'b0));
    drive_q.push_back(build_cmd(wcrw_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 1'b0));
    drive_q.push_back(build_cmd(wcrw_pkg::ACT_STOP, 0, 0, 0, 0, 0, 0, 1'b0));
    drive_q.push_back(build_cmd(wcrw_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 1'b0));
    drive_q.push_back(build_cmd(wcrw_pkg::ACT_SET_DRIVE, 0, 0, 0, 0, 100, 100, 1'b0));
    drive_q.push_back(build_cmd(wcrw_pkg::ACT_STOP_OUTPUT, 0, 0, 0, 0, 0, 0, 1'b0));
    drive_q.push_back(build_cmd(wcrw_pkg::ACT_SET_WHEELS, 0, 0, 0, 0, 0, 0, 1'b0));
    drive_q.push_back(build_cmd(wcrw_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 1'b0));
    drive_q.push_back(build_cmd(wcrw_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 1'b0));
    drive_q.push_back(build_cmd(3'd5, 1, 2, 3, 4, 5, 6, 1'b1));
    drive_q.push_back(build_cmd(3'd6, -1, -2, -3, -4, -5, -6, 1'b0));
    drive_q.push_back(build_cmd(3'd7, 300, 300, 300, 300, 300, 300, 1'b1));
    drive_q.push_back(build_cmd(wcrw_pkg::ACT_SET_WHEELS, -301, 301, -300, 300, 0, 0, 1'b0));
    drive_q.push_back(build_cmd(wcrw_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 1'b1));
    drive_q.push_back(build_cmd(wcrw_pkg::ACT_STOP, 0, 0, 0, 0, 0, 0, 1'b0));
    drain();

    // The watchdog holds off while feedback keeps arriving past the timeout
    // and fires on the first tick without it.
    write_reg(RegUnused, 16'h5a5a);
    write_reg(wcrw_pkg::RegResendPeriod, 3);
    write_reg(wcrw_pkg::RegFeedbackTimeout, 10);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    drive_q.push_back(build_cmd(wcrw_pkg::ACT_SET_WHEELS, 100, -100, 7, 0, 0, 0, 1'b0));
    repeat (16) begin
      drive_q.push_back(build_cmd(wcrw_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 1'b1));
    end
    drive_q.push_back(build_cmd(wcrw_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 1'b0));
    drain();

    // Random phases, each under its own register setting.
    for (p = 0; p < PhaseCount; p++) begin
      drain();
      if (p < PlannedPhases) begin
        write_reg(wcrw_pkg::RegSpeedLimit, limit_plan[p]);
        write_reg(wcrw_pkg::RegResendPeriod, period_plan[p]);
        write_reg(wcrw_pkg::RegFeedbackTimeout, timeout_plan[p]);
      end else begin
        write_reg(wcrw_pkg::RegSpeedLimit, $urandom_range(0, 1) ? $urandom_range(0, 2000)
                                                                : $urandom_range(0, 32767));
        write_reg(wcrw_pkg::RegResendPeriod, $urandom_range(0, 12));
        write_reg(wcrw_pkg::RegFeedbackTimeout, $urandom_range(0, 40));
      end
      tx_idle_en = (p != PhaseCount - 1) && ($urandom_range(0, 3) != 0);
      rx_idle_en = (p != PhaseCount - 1) && ($urandom_range(0, 3) != 0);
      added = 0;
      if (p == 4) begin
        // Receiver holds off while stop requests keep coming, so the block
        // fills up and back-pressures its input.
        rx_hold_left = 300;
        for (n = 0; n < 24; n++) begin
          drive_q.push_back(rand_cmd(n[0] ? wcrw_pkg::ACT_STOP : wcrw_pkg::ACT_STOP_OUTPUT));
          added++;
        end
      end
      while (added < PhaseItems) queue_random_burst(added);
    end
    drain();

    if (mismatch_cnt == 0 && motor_cmd_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #1500000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
